// ===== rtl/tdavg_pkg.sv =====
// Shared types and constants for the decimating averager.
package tdavg_pkg;

  localparam int SCALE_W   = 32;
  localparam int FIELD_W   = 32;
  localparam int STATUS_W  = 24;
  localparam int STAMP_W   = 64;
  localparam int FACTOR_W  = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W     = 3 * FIELD_W + STATUS_W + STAMP_W;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd1;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'h0001_0000;
  localparam logic [FIELD_W-1:0]  FIELD_MAX  = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0]  FIELD_MIN  = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR = 1'b0,
    REG_SCALE  = 1'b1
  } tdavg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_DONE
  } tdavg_state_t;

  // sequencer to the axis lanes
  typedef struct packed {
    logic load;
    logic abs_en;
    logic div_en;
    logic mul_en;
    logic sat_en;
    logic scale_bit;
  } tdavg_lane_ctl_t;

  // sequencer to the top level
  typedef struct packed {
    logic ready;
    logic load_out;
  } tdavg_stat_t;

endpackage

// ===== rtl/tdavg_lane.sv =====
// One axis: magnitude, bit-serial divide, bit-serial multiply by scale, saturation.
module tdavg_lane import tdavg_pkg::*; #(
  parameter int MW = 40,
  parameter int FB = 16
) (
  input  logic                  clk,
  input  tdavg_lane_ctl_t       ctl,
  input  logic [MW-1:0]         start_val,
  input  logic [FB-1:0]         divisor,
  output logic [FIELD_W-1:0]    field
);

  localparam int PW = MW + SCALE_W;

  logic                neg;
  logic [MW-1:0]       work;
  logic [FB-1:0]       rem;
  logic [MW-1:0]       acc;
  logic [SCALE_W-1:0]  lo;

  logic [FB:0]         shifted;
  logic [FB+1:0]       diff;
  logic                fits;
  logic [MW:0]         madd;
  logic [PW-1:0]       prod;
  logic [63:0]         p64;
  logic [55:0]         q;
  logic                over;
  logic [FIELD_W-1:0]  sat_val;

  // restoring divide: one quotient bit per cycle shifts into work
  assign shifted = {rem, work[MW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !diff[FB+1];

  // shift-add multiply, scale lsb first; low product bits fall into lo
  assign madd = {1'b0, acc} + (ctl.scale_bit ? {1'b0, work} : '0);

  // product kept modulo 2^64, then Q16.16 -> Q24.8
  assign prod = {acc, lo};
  assign p64  = 64'(prod);
  assign q    = p64[63:8];
  assign over = |q[55:31];

  always_comb begin
    if (neg) begin
      sat_val = over ? FIELD_MIN : (~q[FIELD_W-1:0] + 1'b1);
    end else begin
      sat_val = over ? FIELD_MAX : q[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= start_val;
    end else if (ctl.abs_en) begin
      neg  <= work[MW-1];
      work <= work[MW-1] ? (~work + 1'b1) : work;
      rem  <= '0;
      acc  <= '0;
    end else if (ctl.div_en) begin
      rem  <= fits ? diff[FB-1:0] : shifted[FB-1:0];
      work <= {work[MW-2:0], fits};
    end else if (ctl.mul_en) begin
      acc <= madd[MW:1];
      lo  <= {madd[0], lo[SCALE_W-1:1]};
    end else if (ctl.sat_en) begin
      field <= sat_val;
    end
  end

endmodule

// ===== rtl/tdavg_ctrl.sv =====
// Sequencer: steps the lanes through magnitude, divide, multiply and saturate.
module tdavg_ctrl import tdavg_pkg::*; #(
  parameter int MW = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SCALE_W-1:0]  scale,
  input  logic                out_free,
  output tdavg_lane_ctl_t     ctl,
  output tdavg_stat_t         stat
);

  localparam int CNT_W = $clog2((MW > SCALE_W) ? MW : SCALE_W);

  tdavg_state_t        state, state_next;
  logic [CNT_W-1:0]    cnt;
  logic [SCALE_W-1:0]  sreg;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_ABS;
      ST_ABS:  state_next = ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_MUL;
      ST_MUL:  if (cnt == '0) state_next = ST_SAT;
      ST_SAT:  state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    stat          = '0;
    ctl.scale_bit = sreg[0];
    unique case (state)
      ST_IDLE: begin
        stat.ready = 1'b1;
        ctl.load   = start;
      end
      ST_ABS:  ctl.abs_en = 1'b1;
      ST_DIV:  ctl.div_en = 1'b1;
      ST_MUL:  ctl.mul_en = 1'b1;
      ST_SAT:  ctl.sat_en = 1'b1;
      ST_DONE: stat.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_ABS:  cnt <= CNT_W'(MW - 1);
        ST_DIV:  cnt <= (cnt == '0) ? CNT_W'(SCALE_W - 1) : cnt - 1'b1;
        ST_MUL:  cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      sreg <= scale;
    end else if (state == ST_MUL) begin
      sreg <= {1'b0, sreg[SCALE_W-1:1]};
    end
  end

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_ABS))
    else $error("start did not leave idle");

  a_sat_then_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SAT) |=> (state == ST_DONE && !stat.ready))
    else $error("saturate step not followed by done");

endmodule

// ===== rtl/three_axis_decimating_averager_core.sv =====
// Top level: config registers, window accumulators, three axis lanes and output register.
// Sequence: an item that closes a window (or any item in pass-through) is loaded into the lanes,
//   runs magnitude, divide, multiply and saturate, then waits for a free output register.
// Flow: no new such item is taken until that result is loaded into the output register; the
//   bit-serial divider (one quotient bit a cycle) and the serial scale multiplier keep it busy.
//   Items that only accumulate are taken every cycle while the sequencer is idle.
// Reset: synchronous; clears accumulators, window count and output valid, factor 1, scale 1.0.
module three_axis_decimating_averager_core import tdavg_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int FACTOR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // raw_x, raw_y, raw_z, sample_status, stamp_us, zero pad
  input  logic [((3*SAMPLE_BITS+STATUS_W+STAMP_W+7)/8)*8-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // field_x, field_y, field_z, out_status, out_stamp_us
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int MW  = SAMPLE_BITS + FACTOR_BITS;
  localparam int SB3 = 3 * SAMPLE_BITS;

  logic [FACTOR_W-1:0]      decim_factor;
  logic [SCALE_W-1:0]       scale;
  logic [MW-1:0]            sum [3];
  logic [MW-1:0]            sum_new [3];
  logic [MW-1:0]            start_val [3];
  logic [FACTOR_BITS-1:0]   window_count;
  logic [FACTOR_BITS-1:0]   count_new;
  logic [FACTOR_BITS-1:0]   factor_eff;
  logic [FACTOR_BITS-1:0]   divisor;
  logic [STATUS_W-1:0]      status_hold;
  logic [STAMP_W-1:0]       stamp_hold;
  logic [FIELD_W-1:0]       field [3];

  logic            accept;
  logic            pass;
  logic            close;
  logic            start;
  logic            out_free;
  tdavg_lane_ctl_t lane_ctl;
  tdavg_stat_t     stat;

  assign factor_eff = decim_factor[FACTOR_BITS-1:0];
  assign pass       = (factor_eff <= FACTOR_BITS'(1));
  assign accept     = s_tvalid && s_tready;
  // count never exceeds the largest factor minus one, so +1 cannot wrap
  assign count_new  = window_count + 1'b1;
  assign close      = (count_new >= factor_eff);
  assign start      = accept && (pass || close);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = stat.ready;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [SAMPLE_BITS-1:0] raw;
    logic [MW-1:0]          sext;

    assign raw          = s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS];
    assign sext         = {{FACTOR_BITS{raw[SAMPLE_BITS-1]}}, raw};
    assign sum_new[a]   = sum[a] + sext;
    assign start_val[a] = pass ? sext : sum_new[a];

    tdavg_lane #(
      .MW (MW),
      .FB (FACTOR_BITS)
    ) u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .start_val (start_val[a]),
      .divisor   (divisor),
      .field     (field[a])
    );
  end

  tdavg_ctrl #(
    .MW (MW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .scale    (scale),
    .out_free (out_free),
    .ctl      (lane_ctl),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      decim_factor <= FACTOR_RST;
      scale        <= SCALE_RST;
      window_count <= '0;
      m_tvalid     <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (tdavg_reg_t'(cfg_index))
          REG_FACTOR: decim_factor <= cfg_data[FACTOR_W-1:0];
          REG_SCALE:  scale        <= cfg_data[SCALE_W-1:0];
        endcase
      end
      if (accept && !pass) begin
        window_count <= close ? '0 : count_new;
        for (int a = 0; a < 3; a++) begin
          sum[a] <= close ? '0 : sum_new[a];
        end
      end
      if (stat.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor     <= pass ? FACTOR_BITS'(1) : factor_eff;
      status_hold <= s_tdata[SB3 +: STATUS_W];
      stamp_hold  <= s_tdata[SB3+STATUS_W +: STAMP_W];
    end
    if (stat.load_out) begin
      m_tdata <= {stamp_hold, status_hold, field[2], field[1], field[0]};
    end
  end

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.load_out))
    else $error("output beat appeared without a finished result");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && !pass && close) |=> (window_count == '0 && sum[0] == '0))
    else $error("window close did not clear the accumulators");

  a_pass_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && pass && !cfg_we) |=> (window_count == $past(window_count)))
    else $error("pass-through changed the window count");

endmodule
